### design/bhr_pkg.sv
// Package for the half-resolution Bayer demosaic core.
// Holds the channel payload types, register codes and fixed field widths.
// No dependencies.
package bhr_pkg;

   // Fixed field widths
   localparam int PIX_W   = 14;
   localparam int COORD_W = 11;
   localparam int CHAN_W  = 15;
   localparam int DIM_W   = 13;
   localparam int GAIN_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   typedef logic [PIX_W-1:0]   pix_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [DIM_W-1:0]   dim_type;
   typedef logic [GAIN_W-1:0]  gain_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_GAIN    = 3'd4;

   // Register reset values
   localparam dim_type  WIDTH_RESET  = 13'd4096;
   localparam dim_type  HEIGHT_RESET = 13'd4096;
   localparam pix_type  BLACK_RESET  = 14'd600;
   localparam gain_type GAIN_RESET   = 16'd8192;

   // Largest channel value after gain
   localparam chan_type CHAN_MAX = 15'h7FFF;

   typedef struct packed {
      pix_type raw_sample;
      logic    frame_start;
   } req_type;

   typedef struct packed {
      coord_type out_col;
      coord_type out_row;
      chan_type  red_value;
      pix_type   green_value;
      chan_type  blue_value;
      logic      frame_last;
   } rsp_type;

endpackage

### design/bhr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read returns the old contents when it hits the address being written.
// No dependencies.
module bhr_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bayer_half_res_demosaic_core.sv
// Top level of the half-resolution RGGB Bayer demosaic core.
// Uses bhr_pkg (types, register codes) and bhr_ram (column line store).
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  req      | in        | req_valid/req_ready | bhr_pkg::req_type (raw sample)
//  rsp      | out       | rsp_valid/rsp_ready | bhr_pkg::rsp_type (RGB pixel)
//  csr      | in        | csr_wr_en           | csr_index, csr_wdata (write only)
//
// One raw item is taken every clock while req_ready is high. A result reaches
// the output register once the item that completes its 2x2 cell has passed the
// line-store read, the window sums, the gain multiply and rounding.
// The line store holds the three earlier rows of one column in a single RAM
// word, read and written back once per item. Reset clears counters, window and
// pipeline valids; the line store needs no clearing pass. Stages hold on a
// stall and empty stages are filled, so req_ready drops only when all stages
// between the line store and the output register hold items.
module bayer_half_res_demosaic_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bhr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bhr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [bhr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bhr_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);       // column address
   localparam int CW = $clog2(MAX_WIDTH) + 1;   // column compare, holds MAX_WIDTH
   localparam int HW = $clog2(MAX_HEIGHT);      // stored row
   localparam int RW = $clog2(MAX_HEIGHT) + 1;  // row compare, holds MAX_HEIGHT
   localparam int PW = bhr_pkg::PIX_W;
   localparam int WORD_W = 3 * PW;
   localparam int PROD_W = bhr_pkg::PIX_W + bhr_pkg::GAIN_W;

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------
   function automatic logic [CW-1:0] eff_width(input bhr_pkg::dim_type v);
      logic [CW-1:0] e;
      begin
         if (v < 13'd8) begin
            e = CW'(8);
         end else if (32'(v) > MAX_WIDTH) begin
            e = CW'(MAX_WIDTH);
         end else begin
            e = CW'(v);
         end
         e[0] = 1'b0;
         return e;
      end
   endfunction

   function automatic logic [RW-1:0] eff_height(input bhr_pkg::dim_type v);
      logic [RW-1:0] e;
      begin
         if (v < 13'd8) begin
            e = RW'(8);
         end else if (32'(v) > MAX_HEIGHT) begin
            e = RW'(MAX_HEIGHT);
         end else begin
            e = RW'(v);
         end
         e[0] = 1'b0;
         return e;
      end
   endfunction

   function automatic logic [1:0] slot_inc(input logic [1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic bhr_pkg::pix_type slot_get(input logic [WORD_W-1:0] w,
                                                 input logic [1:0] s);
      bhr_pkg::pix_type v;
      begin
         case (s)
            2'd0:    v = w[0*PW +: PW];
            2'd1:    v = w[1*PW +: PW];
            2'd2:    v = w[2*PW +: PW];
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   // 9-3-3-1 quad sum, at most 16 * (2^14 - 1)
   function automatic logic [17:0] quad_sum(input bhr_pkg::pix_type a,
                                            input bhr_pkg::pix_type b,
                                            input bhr_pkg::pix_type c,
                                            input bhr_pkg::pix_type d);
      return 18'(a) * 18'd9 + 18'(b) * 18'd3 + 18'(c) * 18'd3 + 18'(d);
   endfunction

   // Round half up at 12 fractional bits, saturate
   function automatic bhr_pkg::chan_type gain_round(input logic [PROD_W-1:0] p);
      logic [PROD_W:0]    t;
      logic [PROD_W-12:0] q;
      begin
         t = (PROD_W + 1)'(p) + (PROD_W + 1)'(2048);
         q = t[PROD_W:12];
         if (q > (PROD_W - 11)'(bhr_pkg::CHAN_MAX)) begin
            return bhr_pkg::CHAN_MAX;
         end
         return q[bhr_pkg::CHAN_W-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CW-1:0]      width_ff;
   logic [RW-1:0]      height_ff;
   bhr_pkg::pix_type   black_ff;
   bhr_pkg::gain_type  red_gain_ff;
   bhr_pkg::gain_type  blue_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= eff_width(bhr_pkg::WIDTH_RESET);
         height_ff    <= eff_height(bhr_pkg::HEIGHT_RESET);
         black_ff     <= bhr_pkg::BLACK_RESET;
         red_gain_ff  <= bhr_pkg::GAIN_RESET;
         blue_gain_ff <= bhr_pkg::GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bhr_pkg::CSR_FRAME_WIDTH:  width_ff  <= eff_width(csr_wdata[bhr_pkg::DIM_W-1:0]);
            bhr_pkg::CSR_FRAME_HEIGHT: height_ff <= eff_height(csr_wdata[bhr_pkg::DIM_W-1:0]);
            bhr_pkg::CSR_BLACK_OFFSET: black_ff  <= csr_wdata[bhr_pkg::PIX_W-1:0];
            bhr_pkg::CSR_RED_GAIN:     red_gain_ff  <= csr_wdata;
            bhr_pkg::CSR_BLUE_GAIN:    blue_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_emit_ff;
   logic adv1, adv2, adv3, accept;

   assign adv3   = s3_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign adv2   = s2_valid_ff && (!s3_valid_ff || adv3);
   assign adv1   = s1_valid_ff && (!s1_emit_ff || !s2_valid_ff || adv2);
   assign req_ready = !s1_valid_ff || adv1;
   assign accept = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Stage 0: position, black level, line-store read
   // ------------------------------------------------------------------
   logic [AW-1:0] col_ff;
   logic [HW-1:0] row_ff;
   logic [1:0]    slot_ff;

   logic [CW-1:0] c0, c_nx;
   logic [RW-1:0] r0, r_nx;
   logic [1:0]    sl0, sl_nx;
   logic          emit0, last0;
   bhr_pkg::pix_type  samp0;
   bhr_pkg::coord_type ocol0, orow0;
   logic [CW-1:0] cm2;
   logic [RW-1:0] rm2;

   // Resolve this item's position and the one after it
   always_comb begin
      c0  = CW'(col_ff);
      r0  = RW'(row_ff);
      sl0 = slot_ff;
      if (req_data.frame_start) begin
         c0  = '0;
         r0  = '0;
         sl0 = '0;
      end else begin
         if (c0 >= width_ff) begin
            c0  = '0;
            r0  = r0 + RW'(1);
            sl0 = slot_inc(sl0);
         end
         if (r0 >= height_ff) begin
            r0  = '0;
            sl0 = '0;
         end
      end
      c_nx  = c0 + CW'(1);
      r_nx  = r0;
      sl_nx = sl0;
      if (c_nx >= width_ff) begin
         c_nx  = '0;
         r_nx  = r0 + RW'(1);
         sl_nx = slot_inc(sl0);
         if (r_nx >= height_ff) begin
            r_nx  = '0;
            sl_nx = '0;
         end
      end
   end

   assign samp0 = (req_data.raw_sample > black_ff) ? req_data.raw_sample - black_ff : '0;
   assign cm2   = c0 - CW'(2);
   assign rm2   = r0 - RW'(2);
   assign ocol0 = bhr_pkg::coord_type'(cm2 >> 1);
   assign orow0 = bhr_pkg::coord_type'(rm2 >> 1);
   assign emit0 = !c0[0] && !r0[0] && (c0 >= CW'(4)) && (r0 >= RW'(4)) &&
                  (c0 <= width_ff - CW'(2)) && (r0 <= height_ff - RW'(2));
   assign last0 = (c0 == width_ff - CW'(2)) && (r0 == height_ff - RW'(2));

   // Advance position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         col_ff  <= c_nx[AW-1:0];
         row_ff  <= r_nx[HW-1:0];
         slot_ff <= sl_nx;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: window assembly, line-store write-back, weighted sums
   // ------------------------------------------------------------------
   logic [AW-1:0]      s1_col_ff;
   logic [1:0]         s1_slot_ff;
   bhr_pkg::pix_type   s1_samp_ff;
   logic               s1_last_ff;
   bhr_pkg::coord_type s1_ocol_ff, s1_orow_ff;
   logic               s1_fwd_ff;
   logic [WORD_W-1:0]  fwd_word_ff;
   logic               fwd_in;

   logic [WORD_W-1:0]  rd_word, cur_word, wr_word;
   bhr_pkg::pix_type   win_ff [4][3];
   bhr_pkg::pix_type   col3 [4];
   logic [17:0]        red_sum, blu_sum, g_sum_a, g_sum_b;
   logic [18:0]        grn_sum;

   bhr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (adv1),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (c0[AW-1:0]),
      .rd_data (rd_word)
   );

   // Forward the word written in the same cycle as a read of that column
   assign fwd_in   = adv1 && (c0[AW-1:0] == s1_col_ff);
   assign cur_word = s1_fwd_ff ? fwd_word_ff : rd_word;

   assign col3[0] = slot_get(cur_word, s1_slot_ff);
   assign col3[1] = slot_get(cur_word, slot_inc(s1_slot_ff));
   assign col3[2] = slot_get(cur_word, slot_inc(slot_inc(s1_slot_ff)));
   assign col3[3] = s1_samp_ff;

   // Replace the oldest row of this column with the new sample
   always_comb begin
      wr_word = cur_word;
      case (s1_slot_ff)
         2'd0:    wr_word[0*PW +: PW] = s1_samp_ff;
         2'd1:    wr_word[1*PW +: PW] = s1_samp_ff;
         2'd2:    wr_word[2*PW +: PW] = s1_samp_ff;
         default: wr_word = cur_word;
      endcase
   end

   assign red_sum = quad_sum(win_ff[1][1], col3[1], win_ff[3][1], col3[3]);
   assign blu_sum = quad_sum(win_ff[2][2], win_ff[2][0], win_ff[0][2], win_ff[0][0]);
   assign g_sum_a = quad_sum(win_ff[1][2], win_ff[1][0], win_ff[3][2], win_ff[3][0]);
   assign g_sum_b = quad_sum(win_ff[2][1], col3[2], win_ff[0][1], col3[0]);
   assign grn_sum = 19'(g_sum_a) + 19'(g_sum_b);

   // Load stage 1 on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (adv1) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= c0[AW-1:0];
         s1_slot_ff  <= sl0;
         s1_samp_ff  <= samp0;
         s1_emit_ff  <= emit0;
         s1_last_ff  <= last0;
         s1_ocol_ff  <= ocol0;
         s1_orow_ff  <= orow0;
         s1_fwd_ff   <= fwd_in;
         fwd_word_ff <= wr_word;
      end
   end

   // Shift the window one column as the item leaves stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (adv1) begin
         for (int k = 0; k < 4; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
            win_ff[k][2] <= col3[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: averaged channels, gain multiply feeds stage 3
   // ------------------------------------------------------------------
   bhr_pkg::pix_type   s2_red_ff, s2_grn_ff, s2_blu_ff;
   bhr_pkg::coord_type s2_ocol_ff, s2_orow_ff;
   logic               s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv1 && s1_emit_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (adv2) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && s1_emit_ff) begin
         s2_red_ff  <= red_sum[17:4];
         s2_blu_ff  <= blu_sum[17:4];
         s2_grn_ff  <= grn_sum[18:5];
         s2_ocol_ff <= s1_ocol_ff;
         s2_orow_ff <= s1_orow_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: gain products
   // ------------------------------------------------------------------
   logic [PROD_W-1:0]  s3_red_prod_ff, s3_blu_prod_ff;
   bhr_pkg::pix_type   s3_grn_ff;
   bhr_pkg::coord_type s3_ocol_ff, s3_orow_ff;
   logic               s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv2) begin
         s3_valid_ff <= 1'b1;
      end else if (adv3) begin
         s3_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s3_red_prod_ff <= PROD_W'(s2_red_ff) * PROD_W'(red_gain_ff);
         s3_blu_prod_ff <= PROD_W'(s2_blu_ff) * PROD_W'(blue_gain_ff);
         s3_grn_ff      <= s2_grn_ff;
         s3_ocol_ff     <= s2_ocol_ff;
         s3_orow_ff     <= s2_orow_ff;
         s3_last_ff     <= s2_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register: round, saturate, hold until taken
   // ------------------------------------------------------------------
   bhr_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_ff.out_col     <= s3_ocol_ff;
         rsp_ff.out_row     <= s3_orow_ff;
         rsp_ff.red_value   <= gain_round(s3_red_prod_ff);
         rsp_ff.green_value <= s3_grn_ff;
         rsp_ff.blue_value  <= gain_round(s3_blu_prod_ff);
         rsp_ff.frame_last  <= s3_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
